[src/shbh_pkg.sv]
// ----------------------------------------------------------------------------
// shbh_pkg
// Shared codes, constants and round functions of the SHA-1 byte hasher.
// ----------------------------------------------------------------------------
package shbh_pkg;

    localparam logic [1:0] FUNC_ABSORB  = 2'd0;
    localparam logic [1:0] FUNC_FINISH  = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam int BUF_WORDS   = 16;
    localparam int CHAIN_WORDS = 5;
    localparam int ROUNDS      = 80;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic load_w;
        logic step;
        logic shift_h;
    } t_rnd_ctl;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            default: v = 32'hC3D2E1F0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] v;
        if (rnd < 7'd20)      v = 32'h5A827999;
        else if (rnd < 7'd40) v = 32'h6ED9EBA1;
        else if (rnd < 7'd60) v = 32'h8F1BBCDC;
        else                  v = 32'hCA62C1D6;
        return v;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] v;
        if (rnd < 7'd20)                     v = (b & c) | (~b & d);
        else if (rnd < 7'd40 || rnd >= 7'd60) v = b ^ c ^ d;
        else                                 v = (b & c) | (b & d) | (c & d);
        return v;
    endfunction

endpackage

[src/shbh_ram.sv]
// ----------------------------------------------------------------------------
// shbh_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module shbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/shbh_round.sv]
// ----------------------------------------------------------------------------
// shbh_round
// Message schedule window and working variables; one round per cycle while step is set.
// ----------------------------------------------------------------------------
module shbh_round
    import shbh_pkg::*;
(
    input  logic        i_clk,
    input  t_rnd_ctl    i_ctl,
    input  logic [31:0] i_w,
    input  logic [31:0] i_h,
    input  logic [6:0]  i_rnd,
    output logic [31:0] o_a
);

    logic [31:0] r_w [BUF_WORDS];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] w_mix;
    logic [31:0] w_new;
    logic [31:0] t_sum;

    always_comb begin
        w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_new = {w_mix[30:0], w_mix[31]};
        t_sum = {r_a[26:0], r_a[31:27]} + round_f(i_rnd, r_b, r_c, r_d) + r_e + r_w[0]
                + round_k(i_rnd);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_w || i_ctl.step) begin
            for (int i = 0; i < BUF_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BUF_WORDS-1] <= i_ctl.load_w ? i_w : w_new;
        end
        if (i_ctl.shift_h) begin
            r_a <= r_b;
            r_b <= r_c;
            r_c <= r_d;
            r_d <= r_e;
            r_e <= i_h;
        end else if (i_ctl.step) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= t_sum;
        end
    end

    assign o_a = r_a;

endmodule

[src/sha1_byte_stream_hasher_core.sv]
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_core
// SHA-1 hasher fed one message byte per word, with finish and restart.
// ----------------------------------------------------------------------------
// Operation on tuser: absorb, finish, restart. The byte that fills a 64-byte
// block starts a compression: block-RAM load, 80 rounds, then chain RAM
// read-add-write. Finish feeds the padding one byte per cycle through the
// same path (9 to 72 bytes, one or two compressions) and then reads the
// five digest words from the chain RAM. A repeated finish only reads the
// digest. Chain words need no clearing pass: a valid bit per entry returns
// the initial hash until the entry is written.
module sha1_byte_stream_hasher_core
    import shbh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic [1:0]  i_s_tuser,   // func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // status, digest_word, word_index, zero fill
    output logic        o_m_tlast    // last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;
    localparam logic [2:0] S_DIG   = 3'd5;

    localparam int BAW = $clog2(BUF_WORDS);
    localparam int CAW = $clog2(CHAIN_WORDS);

    logic [2:0]             r_state;
    logic [5:0]             r_fill;
    logic [63:0]            r_bitcnt;
    logic                   r_done;
    logic                   r_err;
    logic [23:0]            r_acc;
    logic [63:0]            r_len;
    logic                   r_pad;
    logic                   r_pad_first;
    logic                   r_len_ph;
    logic [6:0]             r_cnt;
    logic [CHAIN_WORDS-1:0] r_cvld;
    logic                   r_cvld_q;
    logic [CAW-1:0]         r_caddr_q;
    logic [2:0]             r_dig_idx;
    logic                   r_dig_rdy;
    logic                   r_out_valid;
    logic                   r_out_status;
    logic [31:0]            r_out_word;
    logic [2:0]             r_out_idx;
    logic                   r_out_last;

    logic           in_acc;
    logic           absorb_ok;
    logic [63:0]    bitcnt_inc;
    logic           pad_len;
    logic [7:0]     pad_byte;
    logic           byte_we;
    logic [7:0]     byte_val;
    logic           buf_we;
    logic [31:0]    buf_wdata;
    logic [31:0]    buf_rdata;
    logic [CAW-1:0] chain_raddr;
    logic [CAW-1:0] chain_waddr;
    logic           chain_we;
    logic [31:0]    chain_rdata;
    logic [31:0]    chain_val;
    logic [31:0]    chain_wdata;
    logic           vld_sel;
    logic [31:0]    work_a;
    t_rnd_ctl       rnd_ctl;

    assign o_s_tready = (r_state == S_IDLE) && !r_out_valid;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign absorb_ok  = in_acc && (i_s_tuser == FUNC_ABSORB) && !r_done && !r_err;
    assign bitcnt_inc = r_bitcnt + 64'd8;

    always_comb begin
        pad_len  = !r_pad_first && (r_len_ph || (r_fill == 6'd56));
        pad_byte = r_pad_first ? PAD_BYTE : (pad_len ? r_len[63:56] : 8'h00);
        byte_we  = absorb_ok || (r_state == S_PAD);
        byte_val = (r_state == S_PAD) ? pad_byte : i_s_tdata;
        buf_we    = byte_we && (r_fill[1:0] == 2'b11);
        buf_wdata = {r_acc, byte_val};
    end

    always_comb begin
        unique case (r_state) inside
            S_LOAD, S_WB: chain_raddr = r_cnt[CAW-1:0];
            S_DIG:        chain_raddr = r_dig_idx[CAW-1:0];
            default:      chain_raddr = '0;
        endcase
        vld_sel = 1'b0;
        for (int i = 0; i < CHAIN_WORDS; i++) begin
            if (chain_raddr == CAW'(i)) vld_sel = r_cvld[i];
        end
        chain_val   = r_cvld_q ? chain_rdata : init_hash(3'(r_caddr_q));
        chain_we    = (r_state == S_WB) && (r_cnt != 7'd0);
        chain_waddr = r_cnt[CAW-1:0] - CAW'(1);
        chain_wdata = chain_val + work_a;

        rnd_ctl.load_w  = (r_state == S_LOAD) && (r_cnt != 7'd0);
        rnd_ctl.step    = (r_state == S_ROUND);
        rnd_ctl.shift_h = ((r_state == S_LOAD) && (r_cnt != 7'd0)
                           && (r_cnt <= 7'(CHAIN_WORDS)))
                          || chain_we;
    end

    shbh_ram #(.WIDTH(32), .DEPTH(BUF_WORDS)) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_fill[5:2]),
        .i_wdata (buf_wdata),
        .i_raddr (r_cnt[BAW-1:0]),
        .o_rdata (buf_rdata)
    );

    shbh_ram #(.WIDTH(32), .DEPTH(CHAIN_WORDS)) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (chain_we),
        .i_waddr (chain_waddr),
        .i_wdata (chain_wdata),
        .i_raddr (chain_raddr),
        .o_rdata (chain_rdata)
    );

    shbh_round u_round (
        .i_clk (i_clk),
        .i_ctl (rnd_ctl),
        .i_w   (buf_rdata),
        .i_h   (chain_val),
        .i_rnd (r_cnt),
        .o_a   (work_a)
    );

    always_ff @(posedge i_clk) begin
        r_cvld_q  <= vld_sel;
        r_caddr_q <= chain_raddr;
        if (byte_we) begin
            r_acc <= {r_acc[15:0], byte_val};
        end
        if (in_acc && (i_s_tuser == FUNC_FINISH)) begin
            r_len <= r_bitcnt;
        end else if ((r_state == S_PAD) && pad_len) begin
            r_len <= {r_len[55:0], 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_bitcnt    <= '0;
            r_done      <= 1'b0;
            r_err       <= 1'b0;
            r_pad       <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ph    <= 1'b0;
            r_cnt       <= '0;
            r_cvld      <= '0;
            r_dig_idx   <= '0;
            r_dig_rdy   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (byte_we) begin
                r_fill <= r_fill + 6'd1;
            end
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                if (chain_we && (chain_waddr == CAW'(i))) r_cvld[i] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_out_word <= '0;
                        r_out_idx  <= '0;
                        r_out_last <= 1'b1;
                        unique case (i_s_tuser)
                            FUNC_ABSORB: begin
                                r_out_valid  <= 1'b1;
                                r_out_status <= r_done || r_err;
                                if (r_done) begin
                                    r_err <= 1'b1;
                                end else if (!r_err) begin
                                    r_bitcnt <= bitcnt_inc;
                                    if (bitcnt_inc == 64'd0) r_err <= 1'b1;
                                    if (r_fill == 6'd63) begin
                                        r_state <= S_LOAD;
                                        r_cnt   <= '0;
                                    end
                                end
                            end
                            FUNC_FINISH: begin
                                if (r_err) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_status <= 1'b1;
                                end else if (r_done) begin
                                    r_state   <= S_DIG;
                                    r_dig_idx <= '0;
                                    r_dig_rdy <= 1'b0;
                                end else begin
                                    r_pad       <= 1'b1;
                                    r_pad_first <= 1'b1;
                                    r_len_ph    <= 1'b0;
                                    r_state     <= S_PAD;
                                end
                            end
                            FUNC_RESTART: begin
                                r_out_valid  <= 1'b1;
                                r_out_status <= 1'b0;
                                r_fill       <= '0;
                                r_bitcnt     <= '0;
                                r_done       <= 1'b0;
                                r_err        <= 1'b0;
                                r_cvld       <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PAD: begin
                    r_pad_first <= 1'b0;
                    if (pad_len) r_len_ph <= 1'b1;
                    if (r_fill == 6'd63) begin
                        r_state <= S_LOAD;
                        r_cnt   <= '0;
                    end
                end
                S_LOAD: begin
                    if (r_cnt == 7'(BUF_WORDS)) begin
                        r_state <= S_ROUND;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_ROUND: begin
                    if (r_cnt == 7'(ROUNDS - 1)) begin
                        r_state <= S_WB;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_WB: begin
                    if (r_cnt == 7'(CHAIN_WORDS)) begin
                        r_cnt <= '0;
                        if (!r_pad) begin
                            r_state <= S_IDLE;
                        end else if (r_len_ph) begin
                            r_pad     <= 1'b0;
                            r_done    <= 1'b1;
                            r_bitcnt  <= '0;
                            r_state   <= S_DIG;
                            r_dig_idx <= '0;
                            r_dig_rdy <= 1'b0;
                        end else begin
                            r_state <= S_PAD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_DIG: begin
                    if (r_dig_rdy && !r_out_valid) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= 1'b0;
                        r_out_word   <= chain_val;
                        r_out_idx    <= r_dig_idx;
                        r_out_last   <= (r_dig_idx == 3'(CHAIN_WORDS - 1));
                        r_dig_rdy    <= 1'b0;
                        if (r_dig_idx == 3'(CHAIN_WORDS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_dig_idx <= r_dig_idx + 3'd1;
                        end
                    end else begin
                        r_dig_rdy <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_idx, r_out_word, r_out_status};
    assign o_m_tlast  = r_out_last;

endmodule
